// File: sv/lfu_replacement_policy_defines.svh
// assertion macros for the lfu replacement tracker
// needs clk and arst_n in the scope where a macro is used
// no other dependencies
`ifndef LFU_REPLACEMENT_POLICY_DEFINES_SVH
`define LFU_REPLACEMENT_POLICY_DEFINES_SVH

// same-cycle implication, held off during reset
`define LFU_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define LFU_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/lfu_pkg.sv
// shared types and constants for the lfu replacement tracker
// no dependencies
package lfu_pkg;

	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int COUNT_BITS_DEF = 16;
	localparam int SEQ_BITS       = 48;
	localparam int KEY_W          = 32;
	localparam int CMD_W          = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_ACCESS = 2'd0,
		CMD_INSERT = 2'd1,
		CMD_EVICT  = 2'd2,
		CMD_REMOVE = 2'd3
	} cmd_t;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SCAN   = 4'b0010,
		ST_LAST   = 4'b0100,
		ST_UPDATE = 4'b1000
	} state_t;

	// flags from the shared compare unit
	typedef struct packed {
		logic key_match;
		logic min_better;
	} cmp_flags_t;

endpackage

// File: sv/lfu_req_if.sv
// request channel: command and key word
// depends on lfu_pkg
interface lfu_req_if;
	logic                      valid;
	logic                      ready;
	logic [lfu_pkg::CMD_W-1:0] cmd;
	logic [lfu_pkg::KEY_W-1:0] key;

	modport source (output valid, cmd, key, input ready);
	modport sink (input valid, cmd, key, output ready);
endinterface

// File: sv/lfu_rsp_if.sv
// response channel: victim key and status flags
// depends on lfu_pkg
interface lfu_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [lfu_pkg::KEY_W-1:0] victim_key;
	logic                      hit;
	logic                      table_full;

	modport source (output valid, victim_key, hit, table_full, input ready);
	modport sink (input valid, victim_key, hit, table_full, output ready);
endinterface

// File: sv/lfu_store.sv
// entry memory: key, use count and age stamp per slot
// one registered read port, one write port; depends on lfu_pkg
module lfu_store #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
	parameter int IDX_W      = $clog2(ENTRIES)
) (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [IDX_W-1:0]             rd_idx,
	output logic [KEY_BITS-1:0]          rd_key,
	output logic [COUNT_BITS-1:0]        rd_cnt,
	output logic [lfu_pkg::SEQ_BITS-1:0] rd_age,
	input  logic                         wr_en,
	input  logic [IDX_W-1:0]             wr_idx,
	input  logic [KEY_BITS-1:0]          wr_key,
	input  logic [COUNT_BITS-1:0]        wr_cnt,
	input  logic [lfu_pkg::SEQ_BITS-1:0] wr_age
);
	import lfu_pkg::*;

	logic [KEY_BITS-1:0]   key_mem [ENTRIES];
	logic [COUNT_BITS-1:0] cnt_mem [ENTRIES];
	logic [SEQ_BITS-1:0]   age_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			key_mem[wr_idx] <= wr_key;
			cnt_mem[wr_idx] <= wr_cnt;
			age_mem[wr_idx] <= wr_age;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_key <= key_mem[rd_idx];
			rd_cnt <= cnt_mem[rd_idx];
			rd_age <= age_mem[rd_idx];
		end
	end

endmodule

// File: sv/lfu_cmp.sv
// shared compare unit: key match and lowest count / oldest stamp test
// depends on lfu_pkg
module lfu_cmp #(
	parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  logic                         ent_valid,
	input  logic [KEY_BITS-1:0]          ent_key,
	input  logic [COUNT_BITS-1:0]        ent_cnt,
	input  logic [lfu_pkg::SEQ_BITS-1:0] ent_age,
	input  logic [KEY_BITS-1:0]          key,
	input  logic                         have_best,
	input  logic [COUNT_BITS-1:0]        best_cnt,
	input  logic [lfu_pkg::SEQ_BITS-1:0] best_age,
	output lfu_pkg::cmp_flags_t          flags
);
	import lfu_pkg::*;

	logic cnt_lt;
	logic cnt_eq;
	logic age_lt;

	assign cnt_lt = ent_cnt < best_cnt;
	assign cnt_eq = ent_cnt == best_cnt;
	assign age_lt = ent_age < best_age;

	// strict compare keeps the lowest slot on a full tie
	assign flags.key_match  = ent_valid && (ent_key == key);
	assign flags.min_better = ent_valid && (!have_best || cnt_lt || (cnt_eq && age_lt));

endmodule

// File: sv/lfu_replacement_policy.sv
// top level of the lfu replacement tracker: sequencer, valid bits, stamp counter
// depends on lfu_pkg, lfu_req_if, lfu_rsp_if, lfu_store, lfu_cmp and the defines header
//
//   port   | dir  | word carried
//   -------+------+------------------------------------------
//   req    | sink | cmd (2 bits), key (32 bits)
//   rsp    | src  | victim_key (32 bits), hit, table_full
//
// a command steps through one memory read per slot through the single read port,
// the last compare, the write-back and reply, then an idle step to take the next word;
// no new command is taken before the write-back of the last one
// the reply word is registered at the write-back and held until it is taken
// reset clears the valid bits, the stamp counter and all handshake state
// the result sits in an output register; a stalled rsp holds the sequencer
// in its write-back step only if the previous word has not been taken
`include "lfu_replacement_policy_defines.svh"

module lfu_replacement_policy #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input logic      clk,
	input logic      arst_n,
	lfu_req_if.sink  req,
	lfu_rsp_if.source rsp
);
	import lfu_pkg::*;

	localparam int IDX_W = $clog2(ENTRIES);

	// sequencer and command registers
	state_t                state_q;
	cmd_t                  cmd_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [IDX_W-1:0]      rd_idx_q;

	// read data tag, registered from the read address alongside the read data
	logic                  chk_s1;
	logic [IDX_W-1:0]      chk_idx_s1;

	// slot occupancy and stamp source
	logic [ENTRIES-1:0]    valid_q;
	logic [SEQ_BITS-1:0]   seq_q;

	// scan results
	logic                  found_q;
	logic [IDX_W-1:0]      best_idx_q;
	logic [COUNT_BITS-1:0] best_cnt_q;
	logic [SEQ_BITS-1:0]   best_age_q;
	logic [KEY_BITS-1:0]   best_key_q;
	logic                  free_found_q;
	logic [IDX_W-1:0]      free_idx_q;

	// output register
	logic                  out_valid_q;
	logic [KEY_W-1:0]      out_victim_q;
	logic                  out_hit_q;
	logic                  out_full_q;

	// memory ports
	logic                  rd_en;
	logic [KEY_BITS-1:0]   rd_key;
	logic [COUNT_BITS-1:0] rd_cnt;
	logic [SEQ_BITS-1:0]   rd_age;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [COUNT_BITS-1:0] wr_cnt;

	cmp_flags_t            flags;
	logic                  ent_valid;
	logic                  take;
	logic                  free_take;
	logic                  req_fire;
	logic                  upd_fire;
	logic                  do_bump;
	logic                  do_insert;
	logic                  do_drop;
	logic [COUNT_BITS-1:0] cnt_next;
	logic [63:0]           key_ext;
	logic [63:0]           victim_ext;
	logic [KEY_BITS-1:0]   key_in;

	// key kept as its low KEY_BITS bits, zero-extended when wider than the port
	assign key_ext    = 64'(req.key);
	assign key_in     = key_ext[KEY_BITS-1:0];
	assign victim_ext = 64'(best_key_q);

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;
	assign upd_fire  = (state_q == ST_UPDATE) && (!out_valid_q || rsp.ready);
	assign rd_en     = (state_q == ST_SCAN);

	assign rsp.valid      = out_valid_q;
	assign rsp.victim_key = out_victim_q;
	assign rsp.hit        = out_hit_q;
	assign rsp.table_full = out_full_q;

	lfu_store #(
		.ENTRIES    (ENTRIES),
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS),
		.IDX_W      (IDX_W)
	) u_store (
		.clk    (clk),
		.rd_en  (rd_en),
		.rd_idx (rd_idx_q),
		.rd_key (rd_key),
		.rd_cnt (rd_cnt),
		.rd_age (rd_age),
		.wr_en  (wr_en),
		.wr_idx (wr_idx),
		.wr_key (key_q),
		.wr_cnt (wr_cnt),
		.wr_age (seq_q)
	);

	assign ent_valid = valid_q[chk_idx_s1];

	lfu_cmp #(
		.KEY_BITS   (KEY_BITS),
		.COUNT_BITS (COUNT_BITS)
	) u_cmp (
		.ent_valid (ent_valid),
		.ent_key   (rd_key),
		.ent_cnt   (rd_cnt),
		.ent_age   (rd_age),
		.key       (key_q),
		.have_best (found_q),
		.best_cnt  (best_cnt_q),
		.best_age  (best_age_q),
		.flags     (flags)
	);

	// evict keeps the running minimum, the others keep the first key match
	always_comb begin
		if (cmd_q == CMD_EVICT) begin
			take = chk_s1 && flags.min_better;
		end else begin
			take = chk_s1 && flags.key_match && !found_q;
		end
	end

	// lowest free slot, picked up on the same pass
	assign free_take = chk_s1 && !ent_valid && !free_found_q;

	// write-back decisions
	assign do_bump   = found_q && ((cmd_q == CMD_ACCESS) || (cmd_q == CMD_INSERT));
	assign do_insert = (cmd_q == CMD_INSERT) && !found_q && free_found_q;
	assign do_drop   = found_q && ((cmd_q == CMD_EVICT) || (cmd_q == CMD_REMOVE));

	// count saturates at all ones, stamp is renewed regardless
	assign cnt_next = (best_cnt_q == '1) ? best_cnt_q : best_cnt_q + COUNT_BITS'(1);

	assign wr_en  = upd_fire && (do_bump || do_insert);
	assign wr_idx = do_bump ? best_idx_q : free_idx_q;
	assign wr_cnt = do_bump ? cnt_next : COUNT_BITS'(1);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			rd_idx_q <= '0;
			chk_s1   <= 1'b0;
		end else begin
			chk_s1 <= (state_q == ST_SCAN);
			unique case (state_q)
				ST_IDLE: begin
					rd_idx_q <= '0;
					if (req_fire) begin
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
					if (rd_idx_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					if (upd_fire) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// command capture, reset-free payload
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_q <= cmd_t'(req.cmd);
			key_q <= key_in;
		end
		chk_idx_s1 <= rd_idx_q;
		if (take) begin
			best_idx_q <= chk_idx_s1;
			best_cnt_q <= rd_cnt;
			best_age_q <= rd_age;
			best_key_q <= rd_key;
		end
		if (free_take) begin
			free_idx_q <= chk_idx_s1;
		end
	end

	// scan flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else if (req_fire) begin
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			if (take) begin
				found_q <= 1'b1;
			end
			if (free_take) begin
				free_found_q <= 1'b1;
			end
		end
	end

	// occupancy and stamp counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			seq_q   <= '0;
		end else if (upd_fire) begin
			if (do_insert) begin
				valid_q[free_idx_q] <= 1'b1;
			end
			if (do_drop) begin
				valid_q[best_idx_q] <= 1'b0;
			end
			if (do_bump || do_insert) begin
				seq_q <= seq_q + SEQ_BITS'(1);
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (upd_fire) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_fire) begin
			out_victim_q <= (found_q && (cmd_q == CMD_EVICT)) ? victim_ext[KEY_W-1:0] : '0;
			out_hit_q    <= found_q;
			out_full_q   <= (cmd_q == CMD_INSERT) && !found_q && !free_found_q;
		end
	end

	// checks
	`LFU_ASSERT_NXT(a_busy_after_accept, req_fire, !req.ready, "ready high right after an accept")
	`LFU_ASSERT_IMP(a_full_no_hit, rsp.valid && rsp.table_full, !rsp.hit, "refused insert flagged as hit")
	`LFU_ASSERT_IMP(a_victim_hit, rsp.valid && (rsp.victim_key != '0), rsp.hit, "victim word without hit")
	`LFU_ASSERT_IMP(a_one_slot_step, 1'b1, $countones(valid_q) <= $countones($past(valid_q)) + 1, "more than one slot filled at once")

endmodule
